[rtl/column_statistics_unit_assert.svh]
// assertion macros for the column statistics unit
`ifndef COLUMN_STATISTICS_UNIT_ASSERT_SVH
`define COLUMN_STATISTICS_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define COLST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define COLST_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/colst_pkg.sv]
// shared types and constants for the column statistics unit
package colst_pkg;

  localparam logic [1:0] KIND_MISSING = 2'd0;
  localparam logic [1:0] KIND_WORD    = 2'd1;
  localparam logic [1:0] KIND_NUMBER  = 2'd2;

  localparam int COUNT_W     = 17;
  localparam int COUNT_MAX   = 131071;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLVL_W      = 3;

  typedef struct packed {
    logic [1:0]         cell_kind;
    logic signed [31:0] cell_value;
    logic               last_cell;
  } cell_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               last;
    logic               counted;
    logic               whole;
  } entry_t;

  typedef struct packed {
    logic [16:0]        row_total;
    logic [16:0]        missing_total;
    logic [16:0]        word_total;
    logic [16:0]        number_total;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               range_valid;
    logic               all_whole;
    logic signed [31:0] mean_value;
    logic [31:0]        std_dev;
    logic               stats_valid;
  } profile_t;

endpackage

[rtl/column_statistics_unit.sv]
// top level of the column statistics unit
// Profiles one column of cells and returns one profile on the cell flagged last.
// The back end takes a missing or word cell straight from idle; a number runs
// through the shared one-bit-a-cycle divider (48 steps for the
// mean update) and the shift-add multiplier (32 steps for the deviation term).
// When the statistics are valid, the closing cell adds the 64-step divide by n-1 and the
// 32-step square root. A four-entry queue lets cells be taken while the back
// end is busy, and the profile sits in an output register until taken.
module column_statistics_unit #(
  parameter int MAX_ROWS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  colst_pkg::cell_t    cell_data,
  input  logic                cell_valid,
  output logic                cell_stall,
  output colst_pkg::profile_t profile,
  output logic                profile_valid,
  input  logic                profile_stall
);

`include "column_statistics_unit_assert.svh"

  colst_pkg::entry_t               wentry, rentry;
  logic                            push, pop, full, empty;
  logic [colst_pkg::QLVL_W-1:0]    level;

  assign cell_stall = full;

  colst_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .cell_data(cell_data), .cell_valid(cell_valid),
    .full(full), .push(push), .entry(wentry)
  );

  colst_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(wentry), .pop(pop),
    .rdata(rentry), .full(full), .empty(empty), .level(level)
  );

  colst_back u_back (
    .clk(clk), .rst(rst), .entry(rentry), .empty(empty), .pop(pop),
    .profile(profile), .profile_valid(profile_valid), .profile_stall(profile_stall)
  );

  `COLST_ASSERT(a_pop_not_empty, pop |-> !empty, "pop from empty queue")
  `COLST_ASSERT(a_level_up, (push && !pop) |=> (level == $past(level) + 1'b1), "queue level")
  `COLST_NEVER(a_no_overfill, full && push, "push into full queue")

endmodule

[rtl/colst_front.sv]
// front end: classifies each cell and applies the row cap
module colst_front #(
  parameter int MAX_ROWS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  colst_pkg::cell_t     cell_data,
  input  logic                 cell_valid,
  input  logic                 full,
  output logic                 push,
  output colst_pkg::entry_t    entry
);

  localparam int CAP = (MAX_ROWS < colst_pkg::COUNT_MAX) ? MAX_ROWS : colst_pkg::COUNT_MAX;
  localparam logic [16:0] CAP_V = CAP[16:0];

  logic [16:0] rows;
  logic        counted;

  assign push    = cell_valid && !full;
  assign counted = rows < CAP_V;

  always_comb begin
    entry.kind    = (cell_data.cell_kind == colst_pkg::KIND_NUMBER) ? colst_pkg::KIND_NUMBER :
                    (cell_data.cell_kind == colst_pkg::KIND_WORD)   ? colst_pkg::KIND_WORD :
                                                                      colst_pkg::KIND_MISSING;
    entry.value   = cell_data.cell_value;
    entry.last    = cell_data.last_cell;
    entry.counted = counted;
    entry.whole   = (cell_data.cell_value[15:0] == 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '0;
    end else if (push) begin
      if (cell_data.last_cell) begin
        rows <= '0;
      end else if (counted) begin
        rows <= rows + 17'd1;
      end
    end
  end

endmodule

[rtl/colst_queue.sv]
// short queue between front and back end
module colst_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  colst_pkg::entry_t             wdata,
  input  logic                          pop,
  output colst_pkg::entry_t             rdata,
  output logic                          full,
  output logic                          empty,
  output logic [colst_pkg::QLVL_W-1:0]  level
);

  colst_pkg::entry_t               mem [colst_pkg::QUEUE_DEPTH];
  logic [colst_pkg::QPTR_W-1:0]    wr_ptr;
  logic [colst_pkg::QPTR_W-1:0]    rd_ptr;

  localparam logic [colst_pkg::QLVL_W-1:0] DEPTH_V = colst_pkg::QUEUE_DEPTH[colst_pkg::QLVL_W-1:0];

  assign full  = (level == DEPTH_V);
  assign empty = (level == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

[rtl/colst_back.sv]
// back end: serial welford update, final divide and square root
module colst_back (
  input  logic                clk,
  input  logic                rst,
  input  colst_pkg::entry_t   entry,
  input  logic                empty,
  output logic                pop,
  output colst_pkg::profile_t profile,
  output logic                profile_valid,
  input  logic                profile_stall
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_MEAN = 4'd2;
  localparam logic [3:0] S_PREP = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_FDIV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]         state;
  logic [16:0]        rows, missing, words, numbers;
  logic signed [31:0] min_v, max_v;
  logic               whole;
  logic signed [47:0] mean;
  logic [63:0]        sum_sq;
  logic signed [31:0] x_hold;
  logic               neg;
  logic               last_hold;
  logic [63:0]        dq;
  logic [16:0]        rem;
  logic [16:0]        dvs;
  logic [6:0]         cnt;
  logic [31:0]        mag_a;
  logic [63:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        acc;
  logic [63:0]        sv;
  logic [33:0]        srem;
  logic [31:0]        sres;

  logic signed [47:0] xq_in, xq_hold;
  logic signed [48:0] delta;
  logic [47:0]        delta_mag;
  logic signed [48:0] d2;
  logic [47:0]        d2_mag;
  logic [17:0]        r_shift;
  logic               q_bit;
  logic [35:0]        s_shift, s_trial;
  logic               s_bit;
  logic [64:0]        sum_ext;
  logic               stats_ok;
  logic               out_free;

  assign pop      = (state == S_IDLE) && !empty;
  assign out_free = !profile_valid || !profile_stall;

  always_comb begin
    xq_in     = {entry.value, 16'd0};
    xq_hold   = {x_hold, 16'd0};
    delta     = {xq_in[47], xq_in} - {mean[47], mean};
    delta_mag = delta[48] ? 48'(-delta) : delta[47:0];
    d2        = {xq_hold[47], xq_hold} - {mean[47], mean};
    d2_mag    = d2[48] ? 48'(-d2) : d2[47:0];
    r_shift   = {rem, dq[63]};
    q_bit     = r_shift >= {1'b0, dvs};
    s_shift   = {srem, sv[63:62]};
    s_trial   = {2'b00, sres, 2'b01};
    s_bit     = s_shift >= s_trial;
    sum_ext   = {1'b0, sum_sq} + {1'b0, acc};
    stats_ok  = (rows >= 17'd2) && (words == 17'd0) && (numbers >= 17'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      profile_valid <= 1'b0;
      rows          <= '0;
      missing       <= '0;
      words         <= '0;
      numbers       <= '0;
      min_v         <= '0;
      max_v         <= '0;
      whole         <= 1'b1;
      mean          <= '0;
      sum_sq        <= '0;
    end else begin
      if (profile_valid && !profile_stall && state != S_EMIT) profile_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            last_hold <= entry.last;
            if (entry.counted) begin
              rows <= rows + 17'd1;
              case (entry.kind)
                colst_pkg::KIND_NUMBER: begin
                  if (numbers == '0 || entry.value < min_v) min_v <= entry.value;
                  if (numbers == '0 || entry.value > max_v) max_v <= entry.value;
                  if (!entry.whole) whole <= 1'b0;
                  numbers <= numbers + 17'd1;
                  dvs     <= numbers + 17'd1;
                  x_hold  <= entry.value;
                  neg     <= delta[48];
                  mag_a   <= delta_mag[47:16];
                  dq      <= {delta_mag, 16'd0};
                  rem     <= '0;
                  cnt     <= 7'd48;
                end
                colst_pkg::KIND_WORD: words <= words + 17'd1;
                default: missing <= missing + 17'd1;
              endcase
            end
            if (entry.counted && entry.kind == colst_pkg::KIND_NUMBER) state <= S_DIV;
            else if (entry.last) state <= S_FIN;
          end
        end
        S_DIV, S_FDIV: begin
          rem <= q_bit ? 17'(r_shift - {1'b0, dvs}) : r_shift[16:0];
          dq  <= {dq[62:0], q_bit};
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            if (state == S_DIV) begin
              state <= S_MEAN;
            end else begin
              sv    <= {dq[62:0], q_bit};
              srem  <= '0;
              sres  <= '0;
              cnt   <= 7'd32;
              state <= S_SQRT;
            end
          end
        end
        S_MEAN: begin
          mean  <= neg ? mean - $signed(dq[47:0]) : mean + $signed(dq[47:0]);
          state <= S_PREP;
        end
        S_PREP: begin
          mul_a <= {32'd0, mag_a};
          mul_b <= d2_mag[47:16];
          acc   <= '0;
          cnt   <= 7'd32;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_b[0]) acc <= acc + mul_a;
          mul_a <= {mul_a[62:0], 1'b0};
          mul_b <= {1'b0, mul_b[31:1]};
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_ACC;
        end
        S_ACC: begin
          sum_sq <= sum_ext[64] ? {64{1'b1}} : sum_ext[63:0];
          state  <= last_hold ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (stats_ok) begin
            dq    <= sum_sq;
            dvs   <= numbers - 17'd1;
            rem   <= '0;
            cnt   <= 7'd64;
            state <= S_FDIV;
          end else begin
            sres  <= '0;
            state <= S_EMIT;
          end
        end
        S_SQRT: begin
          srem  <= s_bit ? 34'(s_shift - s_trial) : s_shift[33:0];
          sres  <= {sres[30:0], s_bit};
          sv    <= {sv[61:0], 2'b00};
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            profile_valid         <= 1'b1;
            profile.row_total     <= rows;
            profile.missing_total <= missing;
            profile.word_total    <= words;
            profile.number_total  <= numbers;
            profile.min_value     <= min_v;
            profile.max_value     <= max_v;
            profile.range_valid   <= (numbers != '0);
            profile.all_whole     <= (numbers != '0) && whole;
            profile.mean_value    <= stats_ok ? mean[47:16] : 32'sd0;
            profile.std_dev       <= stats_ok ? sres : 32'd0;
            profile.stats_valid   <= stats_ok;
            rows    <= '0;
            missing <= '0;
            words   <= '0;
            numbers <= '0;
            min_v   <= '0;
            max_v   <= '0;
            whole   <= 1'b1;
            mean    <= '0;
            sum_sq  <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
